[hw/rtl/ttlp_pkg.sv]
// Shared types, character classes, unit scales and error codes for the TTL text parser.
`timescale 1ns / 1ps
`default_nettype none

package ttlp_pkg;

    // Largest TTL in seconds
    localparam logic [31:0] TTL_MAX = 32'hffff_ffff;

    // Unit scales in seconds
    localparam int unsigned SCALE_S = 1;
    localparam int unsigned SCALE_M = 60;
    localparam int unsigned SCALE_H = 60 * 60;
    localparam int unsigned SCALE_D = 24 * 60 * 60;
    localparam int unsigned SCALE_W = 7 * 24 * 60 * 60;

    // Width that holds the largest scale
    localparam int unsigned SCALE_W_BITS = 20;

    // Largest group value each unit allows
    localparam logic [31:0] LIMIT_S = 32'(32'hffff_ffff / SCALE_S);
    localparam logic [31:0] LIMIT_M = 32'(32'hffff_ffff / SCALE_M);
    localparam logic [31:0] LIMIT_H = 32'(32'hffff_ffff / SCALE_H);
    localparam logic [31:0] LIMIT_D = 32'(32'hffff_ffff / SCALE_D);
    localparam logic [31:0] LIMIT_W = 32'(32'hffff_ffff / SCALE_W);

    // Error codes
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_EMPTY       = 3'd1;
    localparam logic [2:0] ERR_NO_LAST_UNIT = 3'd2;
    localparam logic [2:0] ERR_BAD_UNIT    = 3'd3;
    localparam logic [2:0] ERR_NO_NUMBER   = 3'd4;
    localparam logic [2:0] ERR_INVALID     = 3'd5;
    localparam logic [2:0] ERR_PART_RANGE  = 3'd6;
    localparam logic [2:0] ERR_TOTAL_RANGE = 3'd7;

    // Character classes decided by the front end
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_BAD,
        CLS_UNIT_S,
        CLS_UNIT_M,
        CLS_UNIT_H,
        CLS_UNIT_D,
        CLS_UNIT_W,
        CLS_BAD_UNIT
    } ttlp_cls_t;

    // Input word
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic       empty_text;
    } ttlp_in_t;

    // Result word
    typedef struct packed {
        logic [31:0] ttl_seconds;
        logic [2:0]  error_code;
    } ttlp_out_t;

    // Classified word held in the queue between front and back
    typedef struct packed {
        ttlp_cls_t  cls;
        logic [3:0] digit;
        logic       last;
        logic       empty_text;
    } ttlp_cls_item_t;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic           valid;
        ttlp_cls_item_t item;
    } ttlp_q_t;

    // Scale of a unit class
    function automatic logic [SCALE_W_BITS-1:0] unit_scale(input ttlp_cls_t cls);
        logic [SCALE_W_BITS-1:0] s;
        case (cls)
            CLS_UNIT_M: s = SCALE_W_BITS'(SCALE_M);
            CLS_UNIT_H: s = SCALE_W_BITS'(SCALE_H);
            CLS_UNIT_D: s = SCALE_W_BITS'(SCALE_D);
            CLS_UNIT_W: s = SCALE_W_BITS'(SCALE_W);
            default:    s = SCALE_W_BITS'(SCALE_S);
        endcase
        return s;
    endfunction

    // Group limit of a unit class
    function automatic logic [31:0] unit_limit(input ttlp_cls_t cls);
        logic [31:0] l;
        case (cls)
            CLS_UNIT_M: l = LIMIT_M;
            CLS_UNIT_H: l = LIMIT_H;
            CLS_UNIT_D: l = LIMIT_D;
            CLS_UNIT_W: l = LIMIT_W;
            default:    l = LIMIT_S;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ttlp_front.sv]
// Front end: classifies each character and holds it in a two-deep queue.
`timescale 1ns / 1ps
`default_nettype none

module ttlp_front
    import ttlp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire ttlp_in_t item,
    output ttlp_q_t       q_head,
    input  wire logic     q_pop
);

    ttlp_cls_item_t      entry_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                wr_en;
    logic                rd_en;
    ttlp_cls_item_t      cls_item;
    logic [7:0]          up_char;

    // Classify the incoming character
    always_comb
    begin
        up_char            = (item.char_code >= 8'h61) ? item.char_code - 8'd32
                                                       : item.char_code;
        cls_item.last       = item.last;
        cls_item.empty_text = item.empty_text;
        cls_item.digit      = item.char_code[3:0];
        if (item.char_code inside {[8'h30:8'h39]})
        begin
            cls_item.cls = CLS_DIGIT;
        end
        else if (item.char_code inside {[8'h41:8'h5a], [8'h61:8'h7a]})
        begin
            case (up_char)
                8'h53:   cls_item.cls = CLS_UNIT_S;
                8'h4d:   cls_item.cls = CLS_UNIT_M;
                8'h48:   cls_item.cls = CLS_UNIT_H;
                8'h44:   cls_item.cls = CLS_UNIT_D;
                8'h57:   cls_item.cls = CLS_UNIT_W;
                default: cls_item.cls = CLS_BAD_UNIT;
            endcase
        end
        else
        begin
            cls_item.cls = CLS_BAD;
        end
    end

    // Queue control
    assign full       = (count_reg == 2'd2);
    assign wr_en      = push && !full;
    assign rd_en      = q_pop && (count_reg != 2'd0);
    assign count_next = count_reg + {1'b0, wr_en} - {1'b0, rd_en};

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= cls_item;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("front queue overfilled");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("front queue pointers out of step");
    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_head.valid) |=> (count_reg == $past(count_reg) + {1'b0, $past(wr_en)}))
        else $error("pop of empty front queue changed its count");

endmodule

`default_nettype wire

[hw/rtl/ttlp_back.sv]
// Back end: accumulates digit groups, scales units, judges errors and queues results.
`timescale 1ns / 1ps
`default_nettype none

module ttlp_back
    import ttlp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire ttlp_q_t q_head,
    output logic         q_pop,
    output logic         empty,
    input  wire logic    pop,
    output ttlp_out_t    result
);

    // Parse state
    logic [63:0] gval_reg,  gval_next;
    logic        gov_reg,   gov_next;
    logic        ghas_reg,  ghas_next;
    logic        gbad_reg,  gbad_next;
    logic        units_reg, units_next;
    logic [31:0] total_reg, total_next;
    logic [2:0]  err_reg,   err_next;

    // Result queue
    ttlp_out_t   res_reg [2];
    logic        res_wr_ptr_reg;
    logic        res_rd_ptr_reg;
    logic [1:0]  res_count_reg;
    logic        res_push;
    logic        res_pop;
    ttlp_out_t   res_word;

    ttlp_cls_item_t          it;
    logic [67:0]             dec_sum;
    logic [SCALE_W_BITS+31:0] product;
    logic [32:0]             total_sum;
    logic [31:0]             limit;
    logic [2:0]              fin_err;
    logic [31:0]             fin_ttl;

    assign it       = q_head.item;
    assign res_pop  = pop && (res_count_reg != 2'd0);
    assign q_pop    = q_head.valid && ((res_count_reg != 2'd2) || res_pop);
    assign empty    = (res_count_reg == 2'd0);
    assign result   = res_reg[res_rd_ptr_reg];

    // Datapath pieces: times ten plus digit, and group times unit scale
    assign dec_sum   = {gval_reg, 3'b000} + {3'b000, gval_reg, 1'b0} + {64'd0, it.digit};
    assign limit     = unit_limit(it.cls);
    assign product   = gval_reg[31:0] * unit_scale(it.cls);
    assign total_sum = {1'b0, total_reg} + {1'b0, product[31:0]};

    // Next parse state and result word
    always_comb
    begin
        gval_next  = gval_reg;
        gov_next   = gov_reg;
        ghas_next  = ghas_reg;
        gbad_next  = gbad_reg;
        units_next = units_reg;
        total_next = total_reg;
        err_next   = err_reg;
        res_push   = 1'b0;
        fin_err    = ERR_OK;
        fin_ttl    = 32'd0;
        res_word   = '0;

        if (q_pop)
        begin
            if (!it.empty_text && err_reg == ERR_OK)
            begin
                case (it.cls)
                    CLS_DIGIT:
                    begin
                        ghas_next = 1'b1;
                        if (!gov_reg)
                        begin
                            if (dec_sum[67:64] != 4'd0)
                            begin
                                gov_next = 1'b1;
                            end
                            else
                            begin
                                gval_next = dec_sum[63:0];
                            end
                        end
                    end
                    CLS_BAD:
                    begin
                        ghas_next = 1'b1;
                        gbad_next = 1'b1;
                    end
                    CLS_BAD_UNIT:
                    begin
                        err_next = ERR_BAD_UNIT;
                    end
                    default:
                    begin
                        // a valid unit letter closes the group
                        units_next = 1'b1;
                        if (!ghas_reg)
                        begin
                            err_next = ERR_NO_NUMBER;
                        end
                        else if (gbad_reg || gov_reg)
                        begin
                            err_next = ERR_INVALID;
                        end
                        else if (gval_reg > {32'd0, limit})
                        begin
                            err_next = ERR_PART_RANGE;
                        end
                        else if (total_sum[32])
                        begin
                            err_next = ERR_TOTAL_RANGE;
                        end
                        else
                        begin
                            total_next = total_sum[31:0];
                            gval_next  = 64'd0;
                            gov_next   = 1'b0;
                            ghas_next  = 1'b0;
                            gbad_next  = 1'b0;
                        end
                    end
                endcase
            end

            // End of text: judge what is left
            if (it.empty_text)
            begin
                fin_err = ERR_EMPTY;
            end
            else if (err_next != ERR_OK)
            begin
                fin_err = err_next;
            end
            else if (!ghas_next)
            begin
                fin_ttl = total_next;
            end
            else if (units_next)
            begin
                fin_err = ERR_NO_LAST_UNIT;
            end
            else if (gbad_next || gov_next)
            begin
                fin_err = ERR_INVALID;
            end
            else if (gval_next[63:32] != 32'd0)
            begin
                fin_err = ERR_TOTAL_RANGE;
            end
            else
            begin
                fin_ttl = gval_next[31:0];
            end

            if (it.empty_text || it.last)
            begin
                res_push             = 1'b1;
                res_word.error_code  = fin_err;
                res_word.ttl_seconds = fin_ttl;
                gval_next  = 64'd0;
                gov_next   = 1'b0;
                ghas_next  = 1'b0;
                gbad_next  = 1'b0;
                units_next = 1'b0;
                total_next = 32'd0;
                err_next   = ERR_OK;
            end
        end
    end

    // Parse state registers and result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gval_reg       <= 64'd0;
            gov_reg        <= 1'b0;
            ghas_reg       <= 1'b0;
            gbad_reg       <= 1'b0;
            units_reg      <= 1'b0;
            total_reg      <= 32'd0;
            err_reg        <= ERR_OK;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            gval_reg  <= gval_next;
            gov_reg   <= gov_next;
            ghas_reg  <= ghas_next;
            gbad_reg  <= gbad_next;
            units_reg <= units_next;
            total_reg <= total_next;
            err_reg   <= err_next;
            if (res_push)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            res_count_reg <= res_count_reg + {1'b0, res_push} - {1'b0, res_pop};
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg[res_wr_ptr_reg] <= res_word;
        end
    end

    // Checks
    a_err_zero_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.error_code != ERR_OK) |-> (res_word.ttl_seconds == 32'd0))
        else $error("error result carries a nonzero TTL");
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count_reg == 2'd2 && !res_pop) |-> !res_push)
        else $error("result queue written while full");
    a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (it.last || it.empty_text)) |=> (res_count_reg != 2'd0))
        else $error("end of text gave no result");
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (err_reg == ERR_OK && !ghas_reg && total_reg == 32'd0))
        else $error("parse state not cleared after a text");

endmodule

`default_nettype wire

[hw/rtl/ttl_text_parser_core.sv]
// Top level of the TTL text parser: front end, classified queue and back end.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | item   : char_code, last, empty_text
//  result   | pop / empty        | result : ttl_seconds, error_code
//
//  One character word is taken per cycle while full is low; once a text's
//  last character leaves the front queue, its result word enters the result queue.
//  The front queue and the result queue are each two words deep, so input
//  keeps flowing while a finished result waits to be popped.
//  full rises only once both queues are full behind a stalled result side.
//  Reset clears all parse state and empties both queues.
`timescale 1ns / 1ps
`default_nettype none

module ttl_text_parser_core
    import ttlp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire ttlp_in_t item,
    output logic          empty,
    input  wire logic     pop,
    output ttlp_out_t     result
);

    ttlp_q_t q_head;
    logic    q_pop;

    // Character classification and queue
    ttlp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // Arithmetic, error judgement and result queue
    ttlp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire
